// ===== hdl/past_pkg.sv =====
package past_pkg;

    // table geometry
    localparam int ADDR_BITS_DEFAULT = 16;
    localparam int ENTRY_BITS        = 2;
    localparam int LANE_BITS         = 3;               // entries per packed word = 2**LANE_BITS
    localparam int LANES             = 1 << LANE_BITS;
    localparam int WORD_W            = LANES * ENTRY_BITS;

    // field widths fixed by the interface
    localparam int KIND_W    = 2;
    localparam int ADDRESS_W = 16;
    localparam int VERDICT_W = 2;

    // transaction kinds
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SCAN  = 2'd2;

    // verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_UNTESTED = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_BLOCKED  = 2'd2;

endpackage

// ===== hdl/packed_address_status_table_unit.sv =====
// Verdict table: one 2-bit verdict per address (0 untested, 1 allowed, 2 blocked), held
// eight to a 16-bit word in a single synchronous RAM of 2**(ADDR_BITS-3) words. Straight
// after reset the unit runs a clearing pass that writes one word per cycle over all
// 2**(ADDR_BITS-3) words (8192 at the default of 16 address bits); in_stall stays high
// for its whole length. After that, each transaction gives exactly one result. A read
// or a write reads the packed word; a write then merges and writes it back; each loads the
// result. A scan reads one word per cycle from the word holding the start address,
// up to 2**(ADDR_BITS-3) words, bound by the single RAM read port; it stops at the
// last entry and does not wrap. Work is one transaction at a time; a new transaction
// is taken while the previous result still sits in the output register, and its own
// finish waits for that register to drain. Input addresses are taken modulo
// 2**ADDR_BITS; found_address carries the low 16 bits of the entry address.
module packed_address_status_table_unit #(
    parameter int ADDR_BITS = past_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,

    // transaction input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [past_pkg::KIND_W-1:0]     kind,
    input  logic [past_pkg::ADDRESS_W-1:0]  address,
    input  logic [past_pkg::VERDICT_W-1:0]  value,

    // result output
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [past_pkg::VERDICT_W-1:0]  status,
    output logic                            found,
    output logic [past_pkg::ADDRESS_W-1:0]  found_address
);

    localparam int LANE_BITS = past_pkg::LANE_BITS;
    localparam int LANES     = past_pkg::LANES;
    localparam int EB        = past_pkg::ENTRY_BITS;
    localparam int WORD_W    = past_pkg::WORD_W;
    localparam int WORD_BITS = ADDR_BITS - LANE_BITS;   // packed word index width
    localparam int DEPTH     = 1 << WORD_BITS;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUSY
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                         state_reg;
    logic [WORD_BITS-1:0]           clr_cnt_reg;    // clearing pass word pointer
    logic [past_pkg::KIND_W-1:0]    kind_reg;
    logic [past_pkg::VERDICT_W-1:0] value_reg;
    logic [LANE_BITS-1:0]           lane_reg;       // entry within word (r/w) or scan start lane
    logic [WORD_BITS-1:0]           cur_reg;        // word whose data arrives this cycle
    logic                           first_reg;      // scan: still on the start word

    logic                           out_valid_reg;
    logic [past_pkg::VERDICT_W-1:0] status_reg;
    logic                           found_reg;
    logic [past_pkg::ADDRESS_W-1:0] found_address_reg;

    // RAM
    logic [WORD_W-1:0]              table_mem [DEPTH];
    logic [WORD_W-1:0]              rd_data_reg;

    // ------------------------------------------------------------------
    // Combinational control
    // ------------------------------------------------------------------
    logic [ADDR_BITS-1:0]           entry_addr;
    logic                           accept;
    logic                           out_free;

    logic                           rd_en;
    logic [WORD_BITS-1:0]           rd_addr;
    logic                           wr_en;
    logic [WORD_BITS-1:0]           wr_addr;
    logic [WORD_W-1:0]              wr_data;

    logic [LANES-1:0]               lane_hit;
    logic                           hit_any;
    logic [LANE_BITS-1:0]           hit_lane;
    logic [ADDR_BITS-1:0]           hit_addr;
    logic                           last_word;
    logic                           finish;
    logic                           advance;
    logic                           load;
    logic [WORD_W-1:0]              merged_word;

    logic [past_pkg::VERDICT_W-1:0] status_next;
    logic                           found_next;
    logic [past_pkg::ADDRESS_W-1:0] found_address_next;

    assign entry_addr = ADDR_BITS'(address);
    assign in_stall   = (state_reg != ST_IDLE);
    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;

    // Blocked-entry search over the word now at the RAM output; lanes below the
    // start address are masked on the first word only. Lowest lane wins.
    always_comb
    begin
        hit_lane = '0;
        for (int i = 0; i < LANES; i++)
        begin
            lane_hit[i] = (rd_data_reg[i*EB +: EB] == past_pkg::VERDICT_BLOCKED)
                          && !(first_reg && (LANE_BITS'(i) < lane_reg));
        end
        for (int i = LANES - 1; i >= 0; i--)
        begin
            if (lane_hit[i])
            begin
                hit_lane = LANE_BITS'(i);
            end
        end
    end

    assign hit_any   = |lane_hit;
    assign hit_addr  = {cur_reg, hit_lane};
    assign last_word = (cur_reg == '1);

    assign finish  = (kind_reg != past_pkg::KIND_SCAN) || hit_any || last_word;
    assign advance = (state_reg == ST_BUSY) && !finish;
    assign load    = (state_reg == ST_BUSY) && finish && out_free;

    // write path: merge the new verdict into the fetched word
    always_comb
    begin
        merged_word = rd_data_reg;
        merged_word[{lane_reg, 1'b0} +: EB] = value_reg;
    end

    // result fields
    always_comb
    begin
        status_next        = '0;
        found_next         = 1'b0;
        found_address_next = '0;
        unique case (kind_reg)
            past_pkg::KIND_READ:
            begin
                status_next = rd_data_reg[{lane_reg, 1'b0} +: EB];
            end
            past_pkg::KIND_SCAN:
            begin
                found_next = hit_any;
                if (hit_any)
                begin
                    found_address_next = past_pkg::ADDRESS_W'(hit_addr);
                end
            end
            default:
            begin
                // write and the unused kind return zeros
            end
        endcase
    end

    // RAM port control: fetch on accept, next word while scanning
    always_comb
    begin
        rd_en   = accept || advance;
        rd_addr = advance ? (cur_reg + WORD_BITS'(1)) : entry_addr[ADDR_BITS-1:LANE_BITS];

        wr_en   = 1'b0;
        wr_addr = cur_reg;
        wr_data = merged_word;
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = {LANES{past_pkg::VERDICT_UNTESTED}};
        end
        else if (load && (kind_reg == past_pkg::KIND_WRITE))
        begin
            wr_en = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Verdict RAM, registered read
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer and output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            clr_cnt_reg       <= '0;
            kind_reg          <= '0;
            value_reg         <= '0;
            lane_reg          <= '0;
            cur_reg           <= '0;
            first_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
            status_reg        <= '0;
            found_reg         <= 1'b0;
            found_address_reg <= '0;
        end
        else
        begin
            // a new result replaces the one leaving in the same cycle
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + WORD_BITS'(1);
                    if (clr_cnt_reg == '1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg  <= kind;
                        value_reg <= value;
                        lane_reg  <= entry_addr[LANE_BITS-1:0];
                        cur_reg   <= entry_addr[ADDR_BITS-1:LANE_BITS];
                        first_reg <= 1'b1;
                        state_reg <= ST_BUSY;
                    end
                end
                ST_BUSY:
                begin
                    if (advance)
                    begin
                        cur_reg   <= cur_reg + WORD_BITS'(1);
                        first_reg <= 1'b0;
                    end
                    else if (load)
                    begin
                        status_reg        <= status_next;
                        found_reg         <= found_next;
                        found_address_reg <= found_address_next;
                        state_reg         <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign found         = found_reg;
    assign found_address = found_address_reg;

`ifndef NO_ASSERTIONS
    // the table is never written while waiting for a transaction
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg != ST_IDLE))
        else $error("RAM write while idle");

    // scan walks the table one word per cycle
    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (cur_reg == $past(cur_reg) + WORD_BITS'(1)))
        else $error("scan cursor skipped a word");

    // a found result never carries a status, and no find means address zero
    a_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((!found_reg || status_reg == '0)
                           && (found_reg || found_address_reg == '0)))
        else $error("inconsistent result fields");

    // a result only loads when the output register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !load)
        else $error("result register overwritten");
`endif

endmodule

// ===== bench/verdict_table_monitor.sv =====
module verdict_table_monitor #(
    parameter int ADDR_BITS = past_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [past_pkg::KIND_W-1:0]     kind,
    input  logic [past_pkg::ADDRESS_W-1:0]  address,
    input  logic [past_pkg::VERDICT_W-1:0]  value,

    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [past_pkg::VERDICT_W-1:0]  status,
    input  logic                            found,
    input  logic [past_pkg::ADDRESS_W-1:0]  found_address,

    output int                              mismatches,
    output int                              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KIND_W      = past_pkg::KIND_W;
    localparam int ADDRESS_W   = past_pkg::ADDRESS_W;
    localparam int VERDICT_W   = past_pkg::VERDICT_W;
    localparam int ENTRIES     = 1 << ADDR_BITS;
    localparam int SHOWN_LIMIT = 10;

    typedef struct packed {
        logic [VERDICT_W-1:0] status;
        logic                 found;
        logic [ADDRESS_W-1:0] found_address;
    } verdict_answer_t;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [ADDRESS_W-1:0] address;
        verdict_answer_t      answer;
    } answer_due_t;

    logic [VERDICT_W-1:0] verdict_copy [ENTRIES];
    answer_due_t          answers_due [$];
    int                   fail_tally = 0;

    // applies one transaction to the local table and returns what the unit must answer
    function automatic verdict_answer_t apply_table_op(
        input logic [KIND_W-1:0]    op,
        input logic [ADDRESS_W-1:0] where,
        input logic [VERDICT_W-1:0] verdict
    );
        verdict_answer_t ans;
        int              idx;
        ans = '0;
        idx = int'(where) & (ENTRIES - 1);
        case (op)
            past_pkg::KIND_READ:
                ans.status = verdict_copy[idx];
            past_pkg::KIND_WRITE:
                verdict_copy[idx] = verdict;
            past_pkg::KIND_SCAN:
                // walks upwards only; no wrap past the last entry
                while (idx < ENTRIES && !ans.found)
                begin
                    if (verdict_copy[idx] == past_pkg::VERDICT_BLOCKED)
                    begin
                        ans.found         = 1'b1;
                        ans.found_address = ADDRESS_W'(idx);
                    end
                    idx++;
                end
            default:
                ;
        endcase
        return ans;
    endfunction

    task automatic note_failure(input string what);
        fail_tally++;
        if (fail_tally <= SHOWN_LIMIT)
            $display("%0t ns  %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_answer_t got;
        answer_due_t     due;
        if (!rst_n)
        begin
            foreach (verdict_copy[i])
                verdict_copy[i] = past_pkg::VERDICT_UNTESTED;
            answers_due.delete();
        end
        else
        begin
            // retire before predicting: no answer may leave in the cycle its request enters
            if (out_valid && !out_stall)
            begin
                got = {status, found, found_address};
                if (answers_due.size() == 0)
                    note_failure($sformatf("unexpected result: status %0d found %0d address %h",
                                           got.status, got.found, got.found_address));
                else
                begin
                    due = answers_due.pop_front();
                    if (got.status !== due.answer.status)
                        note_failure($sformatf("kind %0d @%h: status expected %0d, got %0d",
                                               due.kind, due.address,
                                               due.answer.status, got.status));
                    if (got.found !== due.answer.found)
                        note_failure($sformatf("kind %0d @%h: found expected %0d, got %0d",
                                               due.kind, due.address,
                                               due.answer.found, got.found));
                    if (got.found_address !== due.answer.found_address)
                        note_failure($sformatf("kind %0d @%h: found_address expected %h, got %h",
                                               due.kind, due.address,
                                               due.answer.found_address, got.found_address));
                end
            end
            if (in_valid && !in_stall)
            begin
                due.kind    = kind;
                due.address = address;
                due.answer  = apply_table_op(kind, address, value);
                answers_due = {answers_due, due};
            end
        end
        mismatches  <= fail_tally;
        outstanding <= answers_due.size();
    end

endmodule

// ===== bench/packed_address_status_table_unit_test.sv =====
// Top of the bench: clock, reset, transaction stimulus and the verdict.
// Prediction and comparison sit in verdict_table_monitor beside the unit.
module packed_address_status_table_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_BITS = past_pkg::ADDR_BITS_DEFAULT;
    localparam int KIND_W    = past_pkg::KIND_W;
    localparam int ADDRESS_W = past_pkg::ADDRESS_W;
    localparam int VERDICT_W = past_pkg::VERDICT_W;

    // codes the package leaves unnamed
    localparam logic [KIND_W-1:0]    KIND_UNUSED     = 2'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_ALLOWED = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_SPARE   = 2'd3;

    localparam int RANDOM_TRANSACTIONS = 1450;
    localparam int PHASES              = 3;
    localparam int HOLD_CYCLES         = 300;  // long output back-pressure in the last phase
    localparam int DRAIN_CYCLES        = 20;   // ample margin after the last result
    localparam int RESET_CYCLES        = 5;

    // Run limit. The clearing pass and a scan over an empty table each cover the whole
    // table; only a handful of transactions can walk that far, so the limit stays
    // several times above the slowest correct run.
    localparam longint RUN_LIMIT_NS = 20_000_000;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic [KIND_W-1:0]     kind          = past_pkg::KIND_READ;
    logic [ADDRESS_W-1:0]  address       = '0;
    logic [VERDICT_W-1:0]  value         = past_pkg::VERDICT_UNTESTED;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic [VERDICT_W-1:0]  status;
    logic                  found;
    logic [ADDRESS_W-1:0]  found_address;

    int mismatches;
    int outstanding;

    // idling percentages, changed only between phases
    int send_idle_pct = 7;
    int recv_idle_pct = 52;

    // long hold-off: stimulus bumps the request count, the receiver process counts it out
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    always #2 clk = ~clk;

    packed_address_status_table_unit #(
        .ADDR_BITS     (ADDR_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .address       (address),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .found         (found),
        .found_address (found_address)
    );

    verdict_table_monitor #(
        .ADDR_BITS     (ADDR_BITS)
    ) monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .address       (address),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .found         (found),
        .found_address (found_address),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Receiver side. One assignment to out_stall per edge: either the hold-off
    // is running, a new one starts, or the random stall for this phase applies.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end

    // Offers one transaction, with random idle cycles in front of it, and returns at
    // the edge that accepts it. Called at a rising edge, so valid is only ever given
    // one nonblocking assignment per step.
    task automatic offer(
        input logic [KIND_W-1:0]    op,
        input logic [ADDRESS_W-1:0] where,
        input logic [VERDICT_W-1:0] verdict
    );
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= op;
        address  <= where;
        value    <= verdict;
        @(posedge clk);
        // in_stall as seen here is the value the unit held up to this edge
        while (in_stall)
            @(posedge clk);
    endtask

    // Addresses cluster in the bottom and top 256 entries so that reads and scans
    // meet earlier writes; the rest spread over the whole table. Scans rarely start
    // anywhere, since a scan over empty space walks one packed word of eight entries at a time.
    function automatic logic [ADDRESS_W-1:0] pick_address(input bit for_scan);
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < (for_scan ? 5 : 30))
            return ADDRESS_W'($urandom_range(65535, 0));
        else if (roll < (for_scan ? 50 : 65))
            return {8'h00, 8'($urandom)};
        else
            return {8'hFF, 8'($urandom)};
    endfunction

    task automatic offer_random_transaction();
        int                   roll;
        logic [KIND_W-1:0]    op;
        logic [VERDICT_W-1:0] verdict;
        roll = $urandom_range(99, 0);
        if (roll < 45)
            op = past_pkg::KIND_WRITE;
        else if (roll < 75)
            op = past_pkg::KIND_READ;
        else if (roll < 95)
            op = past_pkg::KIND_SCAN;
        else
            op = KIND_UNUSED;
        // blocked is favoured so that scans usually stop early
        if ($urandom_range(99, 0) < 40)
            verdict = past_pkg::VERDICT_BLOCKED;
        else
            verdict = VERDICT_W'($urandom);
        offer(op, pick_address(op == past_pkg::KIND_SCAN), verdict);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part -------------------------------------------------------
        // The unit holds in_stall through its clearing pass; offer() just waits.
        // empty table: walks to the end, none
        offer(past_pkg::KIND_SCAN,  16'h0000, past_pkg::VERDICT_UNTESTED);
        // cleared entry reads untested
        offer(past_pkg::KIND_READ,  16'h0000, VERDICT_SPARE);
        // last entry of the table
        offer(past_pkg::KIND_WRITE, 16'hFFFF, past_pkg::VERDICT_BLOCKED);
        // finds it from the word below the last one
        offer(past_pkg::KIND_SCAN,  16'hFFF0, past_pkg::VERDICT_UNTESTED);
        // start address itself blocked
        offer(past_pkg::KIND_SCAN,  16'hFFFF, past_pkg::VERDICT_UNTESTED);
        // neighbours in one packed word: each write must leave the others alone;
        // verdict three stored as given
        offer(past_pkg::KIND_WRITE, 16'h0000, VERDICT_SPARE);
        offer(past_pkg::KIND_WRITE, 16'h0001, VERDICT_ALLOWED);
        offer(past_pkg::KIND_WRITE, 16'h0002, past_pkg::VERDICT_BLOCKED);
        // last lane of the first word, then first lane of the next
        offer(past_pkg::KIND_WRITE, 16'h0007, past_pkg::VERDICT_BLOCKED);
        offer(past_pkg::KIND_WRITE, 16'h0008, past_pkg::VERDICT_BLOCKED);
        offer(past_pkg::KIND_READ,  16'h0000, past_pkg::VERDICT_UNTESTED);
        offer(past_pkg::KIND_READ,  16'h0001, past_pkg::VERDICT_UNTESTED);
        offer(past_pkg::KIND_READ,  16'h0002, past_pkg::VERDICT_UNTESTED);
        offer(past_pkg::KIND_READ,  16'h0003, past_pkg::VERDICT_UNTESTED);
        // the first passes over verdict three; the second starts above it
        offer(past_pkg::KIND_SCAN,  16'h0000, past_pkg::VERDICT_UNTESTED);
        offer(past_pkg::KIND_SCAN,  16'h0003, past_pkg::VERDICT_UNTESTED);
        // long walk up to the last entry
        offer(past_pkg::KIND_SCAN,  16'h0009, past_pkg::VERDICT_UNTESTED);
        offer(past_pkg::KIND_WRITE, 16'hFFFF, past_pkg::VERDICT_UNTESTED);
        // blocked entries lie below: no wrap
        offer(past_pkg::KIND_SCAN,  16'hFFF0, past_pkg::VERDICT_UNTESTED);
        // must change nothing, answer zeros
        offer(KIND_UNUSED,          16'h0002, VERDICT_ALLOWED);
        offer(past_pkg::KIND_READ,  16'h0002, VERDICT_ALLOWED);
        offer(past_pkg::KIND_WRITE, 16'hAAAA, VERDICT_ALLOWED);
        offer(past_pkg::KIND_WRITE, 16'h5555, past_pkg::VERDICT_BLOCKED);
        // fences just above the low cluster and mid-table keep random scans short
        offer(past_pkg::KIND_WRITE, 16'h0100, past_pkg::VERDICT_BLOCKED);
        offer(past_pkg::KIND_WRITE, 16'h8000, past_pkg::VERDICT_BLOCKED);

        // --- random part, three idling phases ------------------------------------
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct <= 7;
                    recv_idle_pct <= 52;
                end
                1:
                begin
                    send_idle_pct <= 52;
                    recv_idle_pct <= 7;
                end
                default:
                begin
                    // no idling; the receiver holds off once so the unit fills and stalls
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                    hold_requests <= hold_requests + 1;
                end
            endcase
            repeat (RANDOM_TRANSACTIONS / PHASES)
                offer_random_transaction();
        end
        in_valid <= 1'b0;

        // --- wind-down ------------------------------------------------------------
        // the count seen at an edge is the one from the edge before, so let the
        // last acceptance show up first
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // hang guard
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
